// ===== design/zpc_pkg.sv =====
// Shared constants and types for the zero-padded 3x3 convolution block.
`default_nettype none

package zpc_pkg;

  // Parameter defaults
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int PIXEL_BITS_DEF = 16;

  // Fixed field widths
  localparam int KSIZE         = 3;   // kernel is KSIZE x KSIZE
  localparam int KCOEF_BITS    = 16;
  localparam int KROW_BITS     = KSIZE * KCOEF_BITS;
  localparam int DIM_REG_BITS  = 11;
  localparam int POS_BITS      = 10;
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = KROW_BITS;

  // Reset values of the frame size registers
  localparam logic [DIM_REG_BITS-1:0] FRAME_WIDTH_RST  = DIM_REG_BITS'(4);
  localparam logic [DIM_REG_BITS-1:0] FRAME_HEIGHT_RST = DIM_REG_BITS'(4);

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_BITS-1:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_KERNEL_TOP   = 3'd2,
    CFG_KERNEL_MID   = 3'd3,
    CFG_KERNEL_BOT   = 3'd4
  } cfg_addr_t;

  // Which window borders fall outside the frame
  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
  } border_mask_t;

endpackage

`default_nettype wire

// ===== design/zero_padded_3x3_convolution_top.sv =====
// Streaming 3x3 convolution with zero padding: line stores, window and MAC pipeline.
`default_nettype none

// Pixels arrive in raster order on the in_ stream, one transaction per cycle at
// full rate; each transaction carries a signed pixel in in_tdata and a drain
// flag in in_tuser (a drain transaction counts as a zero pixel). For each pixel
// the block returns the 3x3 correlation of the unflipped kernel with its
// neighborhood, zero outside the frame, as an exact signed sum together with
// the pixel's row and column; out_tlast marks the last pixel of the frame. An
// output leaves one row plus one pixel after its center, so after the last
// pixel of a frame the source sends frame_width+1 drain transactions; the first
// frame_width+1 transactions of a frame return nothing. After the last output
// all position counters restart for the next frame. Throughput is one
// transaction per cycle: a pixel is taken every cycle the output side is not
// stalled. That rate rests on the line stores, each with one read and one write
// port: a pixel reads its column when taken and writes it back as it leaves the
// input register, and a same-address bypass covers a pixel that follows on the
// same column (one pixel wide frames, the restart after a frame). An input
// transaction reaches the output it completes through the input/line-store
// read register, product register, row-sum register and output register.
// Configuration (frame size, kernel rows) is written through
// cfg_we/cfg_addr/cfg_wdata while no frame is in flight.
// Width and height of zero count as one, values above the maximum as the
// maximum. The line stores need no clearing after reset: entries are always
// written by the first rows of a frame before any non-zeroed tap uses them.
module zero_padded_3x3_convolution_top #(
  parameter int MAX_WIDTH  = zpc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = zpc_pkg::MAX_HEIGHT_DEF,
  parameter int PIXEL_BITS = zpc_pkg::PIXEL_BITS_DEF,
  localparam int PROD_BITS     = zpc_pkg::KCOEF_BITS + PIXEL_BITS,
  localparam int SUM_BITS      = PROD_BITS + 4,
  localparam int IN_DATA_BITS  = ((PIXEL_BITS + 7) / 8) * 8,
  localparam int OUT_DATA_BITS = ((SUM_BITS + 2 * zpc_pkg::POS_BITS + 7) / 8) * 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // configuration write port
  input  wire logic                              cfg_we,
  input  wire logic [zpc_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  wire logic [zpc_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
  // pixel stream
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [IN_DATA_BITS-1:0]           in_tdata,  // pixel_value
  input  wire logic [0:0]                        in_tuser,  // drain
  // result stream
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [OUT_DATA_BITS-1:0]               out_tdata, // conv_value, out_row, out_col
  output logic                                   out_tlast  // last_of_frame
);

  localparam int KS       = zpc_pkg::KSIZE;
  localparam int NTAPS    = KS * KS;
  localparam int KCB      = zpc_pkg::KCOEF_BITS;
  localparam int POSB     = zpc_pkg::POS_BITS;
  localparam int COL_BITS = $clog2(MAX_WIDTH);
  localparam int ROW_BITS = $clog2(MAX_HEIGHT + 2);
  localparam int DIM_W    = $clog2(MAX_WIDTH + 1);
  localparam int DIM_H    = $clog2(MAX_HEIGHT + 1);
  localparam int RSUM_BITS = PROD_BITS + 2;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [zpc_pkg::DIM_REG_BITS-1:0] frame_width_r, frame_height_r;
  logic [zpc_pkg::KROW_BITS-1:0]    kernel_r [KS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= zpc_pkg::FRAME_WIDTH_RST;
      frame_height_r <= zpc_pkg::FRAME_HEIGHT_RST;
      for (int i = 0; i < KS; i++) begin
        kernel_r[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_addr)
        zpc_pkg::CFG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata[zpc_pkg::DIM_REG_BITS-1:0];
        zpc_pkg::CFG_FRAME_HEIGHT: frame_height_r <= cfg_wdata[zpc_pkg::DIM_REG_BITS-1:0];
        zpc_pkg::CFG_KERNEL_TOP:   kernel_r[0]    <= cfg_wdata[zpc_pkg::KROW_BITS-1:0];
        zpc_pkg::CFG_KERNEL_MID:   kernel_r[1]    <= cfg_wdata[zpc_pkg::KROW_BITS-1:0];
        zpc_pkg::CFG_KERNEL_BOT:   kernel_r[2]    <= cfg_wdata[zpc_pkg::KROW_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame size, clamped to 1..MAX
  logic [DIM_W-1:0]    w_eff;
  logic [DIM_H-1:0]    h_eff;
  logic [COL_BITS-1:0] w_m1;
  logic [ROW_BITS-1:0] h_m1;

  always_comb begin
    if (frame_width_r == '0) begin
      w_eff = DIM_W'(1);
    end else if (32'(frame_width_r) > MAX_WIDTH) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = DIM_W'(frame_width_r);
    end
    if (frame_height_r == '0) begin
      h_eff = DIM_H'(1);
    end else if (32'(frame_height_r) > MAX_HEIGHT) begin
      h_eff = DIM_H'(MAX_HEIGHT);
    end else begin
      h_eff = DIM_H'(frame_height_r);
    end
    w_m1 = COL_BITS'(w_eff - DIM_W'(1));
    h_m1 = ROW_BITS'(h_eff) - ROW_BITS'(1);
  end

  // ---------------------------------------------------------------------------
  // Pipeline handshake
  // ---------------------------------------------------------------------------
  logic s1_v_r, s1_res_r, s2_v_r, s3_v_r, s4_v_r;
  logic rdy1, rdy2, rdy3, rdy4, s1_go, in_accept;

  assign rdy4      = !s4_v_r || out_tready;
  assign rdy3      = !s3_v_r || rdy4;
  assign rdy2      = !s2_v_r || rdy3;
  assign s1_go     = s1_v_r && (!s1_res_r || rdy2);   // item leaves the input stage
  assign rdy1      = !s1_v_r || s1_go;
  assign in_tready = rdy1;
  assign in_accept = in_tvalid && rdy1;

  // ---------------------------------------------------------------------------
  // Position counters and output position, decided when a pixel is taken
  // ---------------------------------------------------------------------------
  logic [COL_BITS-1:0] in_col_r, in_col_nxt;
  logic [ROW_BITS-1:0] in_row_r, in_row_nxt;

  logic                  cand, res, last;
  logic [ROW_BITS-1:0]   crow;
  logic [COL_BITS-1:0]   ccol;
  logic [COL_BITS:0]     col_inc;
  logic [ROW_BITS:0]     row_inc, h_p1;
  zpc_pkg::border_mask_t mask;

  always_comb begin
    if (in_col_r == '0) begin
      // center is the last column two rows back
      cand = (in_row_r >= ROW_BITS'(2));
      crow = in_row_r - ROW_BITS'(2);
      ccol = w_m1;
    end else begin
      cand = (in_row_r >= ROW_BITS'(1)) && ((in_col_r - COL_BITS'(1)) < w_eff);
      crow = in_row_r - ROW_BITS'(1);
      ccol = in_col_r - COL_BITS'(1);
    end
    res  = cand && (crow < ROW_BITS'(h_eff));
    last = (crow == h_m1) && (ccol == w_m1);

    mask.top    = (crow == '0);
    mask.bottom = (crow == h_m1);
    mask.left   = (ccol == '0);
    mask.right  = (ccol == w_m1);

    col_inc = (COL_BITS + 1)'(in_col_r) + (COL_BITS + 1)'(1);
    h_p1    = (ROW_BITS + 1)'(h_eff) + (ROW_BITS + 1)'(1);
    if (col_inc >= (COL_BITS + 1)'(w_eff)) begin
      in_col_nxt = '0;
      row_inc    = (ROW_BITS + 1)'(in_row_r) + (ROW_BITS + 1)'(1);
    end else begin
      in_col_nxt = COL_BITS'(col_inc);
      row_inc    = (ROW_BITS + 1)'(in_row_r);
    end
    in_row_nxt = ROW_BITS'(row_inc);
    // frame done (last output) or counters ran past the drain tail
    if ((res && last) || (row_inc > h_p1) || ((row_inc == h_p1) && (in_col_nxt != '0))) begin
      in_col_nxt = '0;
      in_row_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r <= '0;
      in_row_r <= '0;
    end else if (in_accept) begin
      in_col_r <= in_col_nxt;
      in_row_r <= in_row_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: input register and line-store read
  // ---------------------------------------------------------------------------
  logic [PIXEL_BITS-1:0] px_in;
  logic                  fwd;

  logic [PIXEL_BITS-1:0] s1_px_r, s1_up_r, s1_lo_r;
  logic [COL_BITS-1:0]   s1_k_r;
  logic                  s1_last_r;
  logic [POSB-1:0]       s1_row_r, s1_col_r;
  zpc_pkg::border_mask_t s1_mask_r;

  logic [PIXEL_BITS-1:0] line_upper [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] line_lower [MAX_WIDTH];

  assign px_in = in_tuser[0] ? '0 : in_tdata[PIXEL_BITS-1:0];
  // item leaving stage 1 writes the address the new one reads
  assign fwd   = s1_go && (s1_k_r == in_col_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      s1_res_r <= 1'b0;
    end else if (rdy1) begin
      s1_v_r   <= in_accept;
      s1_res_r <= in_accept && res;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      line_upper[s1_k_r] <= s1_lo_r;
      line_lower[s1_k_r] <= s1_px_r;
    end
    if (in_accept) begin
      if (fwd) begin
        s1_up_r <= s1_lo_r;
        s1_lo_r <= s1_px_r;
      end else begin
        s1_up_r <= line_upper[in_col_r];
        s1_lo_r <= line_lower[in_col_r];
      end
      s1_px_r   <= px_in;
      s1_k_r    <= in_col_r;
      s1_last_r <= last;
      s1_row_r  <= POSB'(crow);
      s1_col_r  <= POSB'(ccol);
      s1_mask_r <= mask;
    end
  end

  // ---------------------------------------------------------------------------
  // Window shift, border zeroing, nine products
  // ---------------------------------------------------------------------------
  logic        [PIXEL_BITS-1:0] win_r   [NTAPS];
  logic        [PIXEL_BITS-1:0] win_nxt [NTAPS];
  logic signed [PIXEL_BITS-1:0] tap     [NTAPS];
  logic signed [KCB-1:0]        coef    [NTAPS];
  logic signed [PROD_BITS-1:0]  prod_nxt[NTAPS];

  always_comb begin
    for (int a = 0; a < KS; a++) begin
      win_nxt[a * KS + 0] = win_r[a * KS + 1];
      win_nxt[a * KS + 1] = win_r[a * KS + 2];
    end
    win_nxt[2] = s1_up_r;
    win_nxt[5] = s1_lo_r;
    win_nxt[8] = s1_px_r;
    for (int a = 0; a < KS; a++) begin
      for (int b = 0; b < KS; b++) begin
        if ((a == 0 && s1_mask_r.top) || (a == KS - 1 && s1_mask_r.bottom) ||
            (b == 0 && s1_mask_r.left) || (b == KS - 1 && s1_mask_r.right)) begin
          tap[a * KS + b] = '0;
        end else begin
          tap[a * KS + b] = win_nxt[a * KS + b];
        end
        coef[a * KS + b]     = kernel_r[a][KCB * b +: KCB];
        prod_nxt[a * KS + b] = coef[a * KS + b] * tap[a * KS + b];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NTAPS; i++) begin
        win_r[i] <= '0;
      end
    end else if (s1_go) begin
      win_r <= win_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: products; stage 3: row sums; stage 4: output register
  // ---------------------------------------------------------------------------
  logic signed [PROD_BITS-1:0] s2_prod_r [NTAPS];
  logic signed [RSUM_BITS-1:0] s3_rsum_r [KS];
  logic signed [RSUM_BITS-1:0] rsum_nxt  [KS];
  logic signed [SUM_BITS-1:0]  s4_sum_r, sum_nxt;
  logic                        s2_last_r, s3_last_r, s4_last_r;
  logic [POSB-1:0]             s2_row_r, s2_col_r, s3_row_r, s3_col_r, s4_row_r, s4_col_r;

  always_comb begin
    for (int a = 0; a < KS; a++) begin
      rsum_nxt[a] = RSUM_BITS'(s2_prod_r[a * KS + 0]) + RSUM_BITS'(s2_prod_r[a * KS + 1]) +
                    RSUM_BITS'(s2_prod_r[a * KS + 2]);
    end
    sum_nxt = SUM_BITS'(s3_rsum_r[0]) + SUM_BITS'(s3_rsum_r[1]) + SUM_BITS'(s3_rsum_r[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      if (rdy2) s2_v_r <= s1_v_r && s1_res_r;
      if (rdy3) s3_v_r <= s2_v_r;
      if (rdy4) s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_prod_r <= prod_nxt;
      s2_last_r <= s1_last_r;
      s2_row_r  <= s1_row_r;
      s2_col_r  <= s1_col_r;
    end
    if (rdy3) begin
      s3_rsum_r <= rsum_nxt;
      s3_last_r <= s2_last_r;
      s3_row_r  <= s2_row_r;
      s3_col_r  <= s2_col_r;
    end
    if (rdy4) begin
      s4_sum_r  <= sum_nxt;
      s4_last_r <= s3_last_r;
      s4_row_r  <= s3_row_r;
      s4_col_r  <= s3_col_r;
    end
  end

  always_comb begin
    out_tdata                          = '0;
    out_tdata[SUM_BITS-1:0]            = s4_sum_r;
    out_tdata[SUM_BITS +: POSB]        = s4_row_r;
    out_tdata[SUM_BITS + POSB +: POSB] = s4_col_r;
  end

  assign out_tvalid = s4_v_r;
  assign out_tlast  = s4_last_r;

endmodule

`default_nettype wire
